// ----- rtl/gmcs_pkg.sv -----
package gmcs_pkg;

  // request codes
  localparam logic [1:0] REQ_INIT   = 2'd0;
  localparam logic [1:0] REQ_CARVE  = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;
  localparam logic [1:0] REQ_SEARCH = 2'd3;

  // carve directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // search directions, as stored in the search stack tag
  localparam logic [1:0] TAG_UP    = 2'd0;
  localparam logic [1:0] TAG_RIGHT = 2'd1;
  localparam logic [1:0] TAG_DOWN  = 2'd2;
  localparam logic [1:0] TAG_LEFT  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_READY     = 3'd0;
  localparam logic [2:0] ST_CARVED    = 3'd1;
  localparam logic [2:0] ST_BLOCKED   = 3'd2;
  localparam logic [2:0] ST_BACKTRACK = 3'd3;
  localparam logic [2:0] ST_DONE      = 3'd4;
  localparam logic [2:0] ST_TRACE     = 3'd5;
  localparam logic [2:0] ST_EXIT      = 3'd6;
  localparam logic [2:0] ST_EXHAUSTED = 3'd7;

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic [6:0] DIM_RESET = 7'd32;
  localparam int         DIM_MIN   = 8;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] tag;
    logic [5:0] col;
    logic [5:0] row;
  } res_t;

endpackage

// ----- rtl/gmcs_ram.sv -----
module gmcs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/grid_maze_carve_and_search.sv -----
// A search step makes up to four neighbor probes, each one map read, and every
// request ends in the output drain that sends its result words. Init runs the
// map clear pass. One request in flight at a time.
// Reset: rows/cols to 32, carver at (3,3), then a clear pass over all
// MAX_ROWS*MAX_COLS addresses of both maps; no request is taken until it ends.
module grid_maze_carve_and_search
  import gmcs_pkg::*;
#(
  parameter int MAX_ROWS           = 64,
  parameter int MAX_COLS           = 64,
  parameter int CARVE_STACK_DEPTH  = 1024,
  parameter int SEARCH_STACK_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] req_type, [3:2] rand_dir
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [5:0] cell_row, [11:6] cell_col,
                                      // [13:12] cell_tag, [16:14] status
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CWD  = $clog2(MAX_COLS);
  localparam int MXW  = (RW > CWD) ? RW : CWD;
  localparam int HW   = (MXW + 1 > 7) ? MXW + 1 : 7;
  localparam int MAP_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW   = $clog2(MAP_DEPTH);
  localparam int CSW  = $clog2(CARVE_STACK_DEPTH);
  localparam int CDW  = $clog2(CARVE_STACK_DEPTH + 1);
  localparam int SSW  = $clog2(SEARCH_STACK_DEPTH);
  localparam int SDW  = $clog2(SEARCH_STACK_DEPTH + 1);
  localparam int CEW  = RW + CWD;
  localparam int SEW  = RW + CWD + 2;
  localparam int H0   = (MAX_ROWS < 32) ? MAX_ROWS : 32;
  localparam int W0   = (MAX_COLS < 32) ? MAX_COLS : 32;
  localparam int START_R0 = (H0 / 2) | 1;
  localparam int START_C0 = (W0 / 2) | 1;

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_OPEN33  = 5'd1;
  localparam logic [4:0] S_IDLE    = 5'd2;
  localparam logic [4:0] S_CRD     = 5'd3;
  localparam logic [4:0] S_CEV     = 5'd4;
  localparam logic [4:0] S_CW1     = 5'd5;
  localparam logic [4:0] S_CW2     = 5'd6;
  localparam logic [4:0] S_CPOP    = 5'd7;
  localparam logic [4:0] S_CPOPEV  = 5'd8;
  localparam logic [4:0] S_CDONE   = 5'd9;
  localparam logic [4:0] S_START   = 5'd10;
  localparam logic [4:0] S_POP     = 5'd11;
  localparam logic [4:0] S_POPEV   = 5'd12;
  localparam logic [4:0] S_PROBE   = 5'd13;
  localparam logic [4:0] S_CHK     = 5'd14;
  localparam logic [4:0] S_PUSH1   = 5'd15;
  localparam logic [4:0] S_PUSH2   = 5'd16;
  localparam logic [4:0] S_DEAD    = 5'd17;
  localparam logic [4:0] S_DEADEV  = 5'd18;
  localparam logic [4:0] S_DRAIN   = 5'd19;

  logic [4:0]     state;
  logic [6:0]     rows, cols;
  logic [AW-1:0]  clr_addr;
  logic           clr_open;
  logic [CDW-1:0] carve_depth;
  logic [RW-1:0]  car_r, start_r, cur_r, trace_r;
  logic [CWD-1:0] car_c, start_c, cur_c, trace_c;
  logic [3:0]     tried;
  logic           carve_fin;
  logic [1:0]     carve_dir;
  logic [SDW-1:0] search_depth;
  logic [1:0]     cur_d, trace_tag;
  logic           trace_v;
  logic           exit_found;
  res_t           rb [2];
  logic [1:0]     rcnt, didx;

  // memory ports
  logic           open_we, open_wd, open_rd;
  logic [AW-1:0]  open_wa, open_ra;
  logic           vis_we, vis_rd;
  logic [AW-1:0]  vis_wa;
  logic           cs_we;
  logic [CSW-1:0] cs_wa, cs_ra;
  logic [CEW-1:0] cs_rd;
  logic           ss_we;
  logic [SSW-1:0] ss_wa, ss_ra;
  logic [SEW-1:0] ss_wd, ss_rd;

  function automatic logic [AW-1:0] map_addr(input logic [HW-1:0] r, input logic [HW-1:0] c);
    return AW'(r * MAX_COLS + c);
  endfunction

  function automatic res_t mk_res(input logic [HW-1:0] r, input logic [HW-1:0] c,
                                  input logic [1:0] tag, input logic [2:0] st);
    res_t x;
    x.row    = r[5:0];
    x.col    = c[5:0];
    x.tag    = tag;
    x.status = st;
    return x;
  endfunction

  // saturated maze size
  logic [HW-1:0] rows_x, cols_x, h, w;
  assign rows_x = HW'(rows);
  assign cols_x = HW'(cols);
  assign h = (rows_x < HW'(DIM_MIN)) ? HW'(DIM_MIN) :
             (rows_x > HW'(MAX_ROWS)) ? HW'(MAX_ROWS) : rows_x;
  assign w = (cols_x < HW'(DIM_MIN)) ? HW'(DIM_MIN) :
             (cols_x > HW'(MAX_COLS)) ? HW'(MAX_COLS) : cols_x;

  // carver target and wall cell
  logic [HW-1:0] rx, cx, tr, tc, mr, mc;
  logic          okpre, bound;
  assign rx = HW'(car_r);
  assign cx = HW'(car_c);
  always_comb begin
    tr = rx; tc = cx; mr = rx; mc = cx;
    unique case (carve_dir)
      DIR_UP:    begin tr = rx - HW'(2); mr = rx - HW'(1); bound = rx > HW'(2); end
      DIR_DOWN:  begin tr = rx + HW'(2); mr = rx + HW'(1); bound = rx < h - HW'(3); end
      DIR_LEFT:  begin tc = cx - HW'(2); mc = cx - HW'(1); bound = cx > HW'(2); end
      default:   begin tc = cx + HW'(2); mc = cx + HW'(1); bound = cx < w - HW'(3); end
    endcase
    okpre = bound && !tried[carve_dir];
  end

  // search neighbor of the current cell
  logic [HW-1:0] sr, sc, nr, nc;
  logic          nb_in, nb_exit;
  assign sr = HW'(cur_r);
  assign sc = HW'(cur_c);
  always_comb begin
    nr = sr; nc = sc;
    unique case (cur_d)
      TAG_UP:    nr = sr - HW'(1);
      TAG_RIGHT: nc = sc + HW'(1);
      TAG_DOWN:  nr = sr + HW'(1);
      default:   nc = sc - HW'(1);
    endcase
  end
  assign nb_in   = (nr < HW'(MAX_ROWS)) && (nc < HW'(MAX_COLS));
  assign nb_exit = (nr == h - HW'(2)) && (nc == w - HW'(2));

  logic [AW-1:0] nb_addr;
  assign nb_addr = nb_in ? map_addr(nr, nc) : '0;

  // stack entry fields
  logic [RW-1:0]  cs_r, ss_r;
  logic [CWD-1:0] cs_c, ss_c;
  logic [1:0]     ss_t;
  assign cs_r = cs_rd[CEW-1 -: RW];
  assign cs_c = cs_rd[CWD-1:0];
  assign ss_r = ss_rd[SEW-1 -: RW];
  assign ss_c = ss_rd[CWD+1:2];
  assign ss_t = ss_rd[1:0];

  logic [CDW-1:0] cdep_m1;
  logic [SDW-1:0] sdep_m1;
  logic           cs_full, ss_full;
  assign cdep_m1 = carve_depth - CDW'(1);
  assign sdep_m1 = search_depth - SDW'(1);
  assign cs_full = carve_depth == CDW'(CARVE_STACK_DEPTH);
  assign ss_full = search_depth == SDW'(SEARCH_STACK_DEPTH);

  // memory port steering
  always_comb begin
    open_we = 1'b0; open_wa = clr_addr; open_wd = 1'b0;
    open_ra = nb_addr;
    vis_we  = 1'b0; vis_wa = clr_addr;
    cs_we   = 1'b0; cs_wa = carve_depth[CSW-1:0];
    cs_ra   = cdep_m1[CSW-1:0];
    ss_we   = 1'b0; ss_wa = search_depth[SSW-1:0];
    ss_wd   = {cur_r, cur_c, cur_d};
    ss_ra   = search_depth[SSW-1:0];
    unique case (state)
      S_CLEAR: begin open_we = 1'b1; vis_we = 1'b1; end
      S_OPEN33: begin
        open_we = 1'b1; open_wd = 1'b1; open_wa = map_addr(HW'(3), HW'(3));
      end
      S_CRD:   open_ra = okpre ? map_addr(tr, tc) : '0;
      S_CW1: begin
        open_we = 1'b1; open_wd = 1'b1; open_wa = map_addr(tr, tc);
        cs_we   = !cs_full;
      end
      S_CW2: begin open_we = 1'b1; open_wd = 1'b1; open_wa = map_addr(mr, mc); end
      S_START: begin
        vis_we = 1'b1; vis_wa = map_addr(HW'(start_r), HW'(start_c));
        ss_we  = 1'b1; ss_wa = '0; ss_wd = {start_r, start_c, TAG_UP};
      end
      S_CHK:   begin vis_we = open_rd && !vis_rd; vis_wa = nb_addr; end
      S_PUSH1: ss_we = !ss_full;
      S_PUSH2: begin ss_we = !ss_full; ss_wd = {nr[RW-1:0], nc[CWD-1:0], TAG_UP}; end
      S_DEAD:  ss_ra = sdep_m1[SSW-1:0];
      default: ;
    endcase
  end

  gmcs_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_open (
    .clk(clk), .we(open_we), .waddr(open_wa), .wdata(open_wd),
    .raddr(open_ra), .rdata(open_rd)
  );

  gmcs_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(1'b1 & (state != S_CLEAR)),
    .raddr(nb_addr), .rdata(vis_rd)
  );

  gmcs_ram #(.WIDTH(CEW), .DEPTH(CARVE_STACK_DEPTH)) u_cstack (
    .clk(clk), .we(cs_we), .waddr(cs_wa), .wdata({car_r, car_c}),
    .raddr(cs_ra), .rdata(cs_rd)
  );

  gmcs_ram #(.WIDTH(SEW), .DEPTH(SEARCH_STACK_DEPTH)) u_sstack (
    .clk(clk), .we(ss_we), .waddr(ss_wa), .wdata(ss_wd),
    .raddr(ss_ra), .rdata(ss_rd)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  logic trace_hit;
  assign trace_hit = trace_v && (trace_r == ss_r) && (trace_c == ss_c) && (trace_tag == ss_t);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= DIM_RESET;
      cols <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS: rows <= cfg_data;
        default:  cols <= cfg_data;
      endcase
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      clr_open     <= 1'b0;
      carve_depth  <= '0;
      car_r        <= RW'(3);
      car_c        <= CWD'(3);
      tried        <= '0;
      carve_fin    <= 1'b0;
      search_depth <= '0;
      start_r      <= RW'(START_R0);
      start_c      <= CWD'(START_C0);
      trace_v      <= 1'b0;
      exit_found   <= 1'b0;
      rcnt         <= '0;
      didx         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        // sweep both maps back to zero
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAP_DEPTH - 1)) begin
            state <= clr_open ? S_OPEN33 : S_IDLE;
          end
        end
        S_OPEN33: begin
          rb[0] <= mk_res(rx, cx, 2'd0, ST_READY);
          rcnt  <= 2'd1;
          state <= S_DRAIN;
        end
        S_IDLE: begin
          rcnt <= '0;
          didx <= '0;
          if (s_axis_tvalid) begin
            unique case (s_axis_tdata[1:0])
              REQ_INIT: begin
                carve_depth  <= '0;
                search_depth <= '0;
                tried        <= '0;
                carve_fin    <= 1'b0;
                trace_v      <= 1'b0;
                exit_found   <= 1'b0;
                car_r        <= RW'(3);
                car_c        <= CWD'(3);
                start_r      <= RW'((h >> 1) | HW'(1));
                start_c      <= CWD'((w >> 1) | HW'(1));
                clr_addr     <= '0;
                clr_open     <= 1'b1;
                state        <= S_CLEAR;
              end
              REQ_CARVE: begin
                carve_dir <= s_axis_tdata[3:2];
                if (carve_fin) begin
                  rb[0] <= mk_res(rx, cx, 2'd0, ST_DONE);
                  rcnt  <= 2'd1;
                  state <= S_DRAIN;
                end else begin
                  state <= S_CRD;
                end
              end
              REQ_START: state <= S_START;
              default: begin
                if (exit_found) begin
                  rb[0] <= mk_res(h - HW'(2), w - HW'(2), 2'd0, ST_EXIT);
                  rcnt  <= 2'd1;
                  state <= S_DRAIN;
                end else if (search_depth == '0) begin
                  rb[0] <= mk_res('0, '0, 2'd0, ST_EXHAUSTED);
                  rcnt  <= 2'd1;
                  state <= S_DRAIN;
                end else begin
                  search_depth <= sdep_m1;
                  state        <= S_POP;
                end
              end
            endcase
          end
        end
        // carve: target read is in flight
        S_CRD: state <= S_CEV;
        S_CEV: begin
          if (okpre && !open_rd) begin
            state <= S_CW1;
          end else begin
            tried <= tried | (4'b0001 << carve_dir);
            rb[0] <= mk_res(rx, cx, 2'd0, ST_BLOCKED);
            rcnt  <= 2'd1;
            if ((tried | (4'b0001 << carve_dir)) == 4'hF) begin
              state <= (carve_depth != '0) ? S_CPOP : S_CDONE;
            end else begin
              state <= S_DRAIN;
            end
          end
        end
        S_CW1: begin
          if (!cs_full) begin
            carve_depth <= carve_depth + CDW'(1);
          end
          state <= S_CW2;
        end
        S_CW2: begin
          car_r <= tr[RW-1:0];
          car_c <= tc[CWD-1:0];
          tried <= '0;
          rb[0] <= mk_res(tr, tc, 2'd0, ST_CARVED);
          rcnt  <= 2'd1;
          state <= S_DRAIN;
        end
        S_CPOP: begin
          carve_depth <= cdep_m1;
          state       <= S_CPOPEV;
        end
        S_CPOPEV: begin
          car_r <= cs_r;
          car_c <= cs_c;
          tried <= '0;
          rb[1] <= mk_res(HW'(cs_r), HW'(cs_c), 2'd0, ST_BACKTRACK);
          rcnt  <= 2'd2;
          state <= S_DRAIN;
        end
        S_CDONE: begin
          carve_fin <= 1'b1;
          rb[1]     <= mk_res(rx, cx, 2'd0, ST_DONE);
          rcnt      <= 2'd2;
          state     <= S_DRAIN;
        end
        // seed the walk at the start cell
        S_START: begin
          search_depth <= SDW'(1);
          exit_found   <= 1'b0;
          rb[0] <= mk_res(HW'(start_r), HW'(start_c), 2'd0, ST_READY);
          rcnt  <= 2'd1;
          state <= S_DRAIN;
        end
        S_POP: state <= S_POPEV;
        S_POPEV: begin
          cur_r <= ss_r;
          cur_c <= ss_c;
          cur_d <= ss_t;
          if (!trace_hit) begin
            rb[0]     <= mk_res(HW'(ss_r), HW'(ss_c), ss_t, ST_TRACE);
            rcnt      <= 2'd1;
            trace_v   <= 1'b1;
            trace_r   <= ss_r;
            trace_c   <= ss_c;
            trace_tag <= ss_t;
          end
          state <= S_PROBE;
        end
        // try the neighbor in direction cur_d
        S_PROBE: begin
          if (nb_exit) begin
            exit_found <= 1'b1;
            rb[rcnt[0]] <= mk_res(nr, nc, 2'd0, ST_EXIT);
            rcnt      <= rcnt + 2'd1;
            trace_v   <= 1'b1;
            trace_r   <= nr[RW-1:0];
            trace_c   <= nc[CWD-1:0];
            trace_tag <= 2'd0;
            state     <= S_DRAIN;
          end else if (nb_in) begin
            state <= S_CHK;
          end else if (cur_d == TAG_LEFT) begin
            state <= S_DEAD;
          end else begin
            cur_d <= cur_d + 2'd1;
          end
        end
        S_CHK: begin
          if (open_rd && !vis_rd) begin
            state <= S_PUSH1;
          end else if (cur_d == TAG_LEFT) begin
            state <= S_DEAD;
          end else begin
            cur_d <= cur_d + 2'd1;
            state <= S_PROBE;
          end
        end
        S_PUSH1: begin
          if (!ss_full) begin
            search_depth <= search_depth + SDW'(1);
          end
          state <= S_PUSH2;
        end
        S_PUSH2: begin
          if (!ss_full) begin
            search_depth <= search_depth + SDW'(1);
          end
          rb[rcnt[0]] <= mk_res(nr, nc, 2'd0, ST_TRACE);
          rcnt      <= rcnt + 2'd1;
          trace_v   <= 1'b1;
          trace_r   <= nr[RW-1:0];
          trace_c   <= nc[CWD-1:0];
          trace_tag <= 2'd0;
          state     <= S_DRAIN;
        end
        // dead end: show the new stack top
        S_DEAD: state <= (search_depth != '0) ? S_DEADEV : S_DRAIN;
        S_DEADEV: begin
          rb[rcnt[0]] <= mk_res(HW'(ss_r), HW'(ss_c), ss_t, ST_TRACE);
          rcnt      <= rcnt + 2'd1;
          trace_v   <= 1'b1;
          trace_r   <= ss_r;
          trace_c   <= ss_c;
          trace_tag <= ss_t;
          state     <= S_DRAIN;
        end
        // hand buffered results to the output word register
        S_DRAIN: begin
          if (didx == rcnt) begin
            state <= S_IDLE;
          end else if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'd0, rb[didx[0]]};
            m_axis_tlast  <= (didx + 2'd1) == rcnt;
            didx          <= didx + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_cdepth: assert property (@(posedge clk) disable iff (rst)
    carve_depth <= CDW'(CARVE_STACK_DEPTH))
    else $error("carve stack depth overrun");

  a_sdepth: assert property (@(posedge clk) disable iff (rst)
    search_depth <= SDW'(SEARCH_STACK_DEPTH))
    else $error("search stack depth overrun");

  a_rbuf: assert property (@(posedge clk) disable iff (rst)
    (rcnt <= 2'd2) && (state != S_DRAIN || didx <= rcnt))
    else $error("result buffer count out of range");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_axis_tready)
    else $error("request taken during clear pass");

  a_one: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while busy");

endmodule
